/* hw/rtl/isms_pkg.sv */
// ----------------------------------------------------------------------------
// isms_pkg
// Shared types and constants for the Ising Metropolis spin update core:
// field widths, command codes, register indexes and reset values.
// ----------------------------------------------------------------------------
package isms_pkg;

   localparam int CMD_W      = 2;
   localparam int COORD_W    = 5;
   localparam int SAMPLE_W   = 16;
   localparam int THRESH_W   = 17;
   localparam int SIDE_REG_W = 6;
   localparam int DE_W       = 5;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 17;

   localparam int MIN_SIDE = 3;

   typedef enum logic [CMD_W-1:0] {
      CMD_UPDATE = 2'd0,
      CMD_WRITE  = 2'd1,
      CMD_READ   = 2'd2
   } cmd_type;

   localparam logic [CSR_IDX_W-1:0] CSR_SIDE       = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_THRESH_FOUR  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_THRESH_EIGHT = 2'd2;

   localparam logic [SIDE_REG_W-1:0] SIDE_RESET         = 6'd32;
   localparam logic [THRESH_W-1:0]   THRESH_FOUR_RESET  = 17'd12113;
   localparam logic [THRESH_W-1:0]   THRESH_EIGHT_RESET = 17'd2239;

   localparam logic signed [DE_W-1:0] DE_ZERO  = 5'sd0;
   localparam logic signed [DE_W-1:0] DE_FOUR  = 5'sd4;
   localparam logic signed [DE_W-1:0] DE_EIGHT = 5'sd8;

   // Per-item control carried from the input register into the evaluation logic
   typedef struct packed {
      cmd_type               command;
      logic [SAMPLE_W-1:0]   uniform_sample;
      logic                  spin_value;
   } eval_ctrl_type;

   typedef struct packed {
      logic                  site_spin;
      logic                  flipped;
      logic [DE_W-1:0]       energy_change;
      logic                  write_en;
   } eval_result_type;

endpackage

/* hw/rtl/ising_metropolis_spin_update_core.sv */
// ----------------------------------------------------------------------------
// ising_metropolis_spin_update_core
// A word accepted at an edge passes through the stage-one register and the
// result register before its result is strobed on rsp_valid.
// Throughput: one word per clock; busy stays low and the result strobe
// cannot be held off by the receiver.
// Reset: control registers return to their defaults and every spin reads +1
// at once through per-row valid flags; no clearing sweep runs.
// ----------------------------------------------------------------------------
module ising_metropolis_spin_update_core #(
   parameter int MAX_SIDE = 32
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  logic [isms_pkg::CMD_W-1:0]       req_command,
   input  logic [isms_pkg::COORD_W-1:0]     req_row_index,
   input  logic [isms_pkg::COORD_W-1:0]     req_column_index,
   input  logic [isms_pkg::SAMPLE_W-1:0]    req_uniform_sample,
   input  logic                             req_spin_value,
   output logic                             rsp_valid,
   output logic                             rsp_site_spin,
   output logic                             rsp_flipped,
   output logic signed [isms_pkg::DE_W-1:0] rsp_energy_change,
   output logic                             rsp_range_error,
   input  logic                             csr_write_enable,
   input  logic [isms_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [isms_pkg::CSR_DATA_W-1:0]  csr_write_data
);

   import isms_pkg::*;

   localparam int RW = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
   localparam int SW = $clog2(MAX_SIDE + 1);
   localparam int CW = (SW > SIDE_REG_W) ? SW : SIDE_REG_W;

   // configuration
   logic [SIDE_REG_W-1:0] side_ff;
   logic [THRESH_W-1:0]   thresh_four_ff;
   logic [THRESH_W-1:0]   thresh_eight_ff;

   logic [MAX_SIDE-1:0]   row_valid_ff;

   // input stage
   logic                  accept;
   logic [CW-1:0]         side_ext;
   logic [CW-1:0]         side_eff;
   logic [CW-1:0]         row_ext;
   logic [CW-1:0]         col_ext;
   logic [CW-1:0]         row_minus_ext;
   logic [CW-1:0]         row_plus_ext;
   logic [CW-1:0]         col_minus_ext;
   logic [CW-1:0]         col_plus_ext;
   logic                  in_range;
   logic [RW-1:0]         row_in;
   logic [RW-1:0]         row_up_in;
   logic [RW-1:0]         row_dn_in;
   logic [RW-1:0]         col_in;
   logic [RW-1:0]         col_minus_in;
   logic [RW-1:0]         col_plus_in;
   eval_ctrl_type         ctrl_in;

   logic                  s1_valid_ff;
   logic                  s1_range_error_ff;
   eval_ctrl_type         s1_ctrl_ff;
   logic [RW-1:0]         s1_row_ff;
   logic [RW-1:0]         s1_row_up_ff;
   logic [RW-1:0]         s1_row_dn_ff;
   logic [RW-1:0]         s1_col_ff;
   logic [RW-1:0]         s1_col_minus_ff;
   logic [RW-1:0]         s1_col_plus_ff;
   logic                  s1_up_valid_ff;
   logic                  s1_mid_valid_ff;
   logic                  s1_dn_valid_ff;

   // row copies and forwarding of the last written row
   logic [MAX_SIDE-1:0]   ram_up_q;
   logic [MAX_SIDE-1:0]   ram_mid_q;
   logic [MAX_SIDE-1:0]   ram_dn_q;
   logic                  byp_valid_ff;
   logic [RW-1:0]         byp_row_ff;
   logic [MAX_SIDE-1:0]   byp_data_ff;
   logic [MAX_SIDE-1:0]   up_row;
   logic [MAX_SIDE-1:0]   mid_row;
   logic [MAX_SIDE-1:0]   dn_row;

   logic [MAX_SIDE-1:0]   new_row;
   eval_result_type       eval_res;
   logic                  wr_en;

   // result register
   logic                  rsp_valid_ff;
   logic                  rsp_site_spin_ff;
   logic                  rsp_flipped_ff;
   logic [DE_W-1:0]       rsp_energy_change_ff;
   logic                  rsp_range_error_ff;
   logic                  rsp_site_spin_in;
   logic                  rsp_flipped_in;
   logic [DE_W-1:0]       rsp_energy_change_in;

   assign busy   = 1'b0;
   assign accept = start && !busy;

   always_comb begin
      side_ext = CW'(side_ff);
      if (side_ext < CW'(MIN_SIDE)) begin
         side_eff = CW'(MIN_SIDE);
      end else if (side_ext > CW'(MAX_SIDE)) begin
         side_eff = CW'(MAX_SIDE);
      end else begin
         side_eff = side_ext;
      end

      row_ext  = CW'(req_row_index);
      col_ext  = CW'(req_column_index);
      in_range = (row_ext < side_eff) && (col_ext < side_eff);

      // periodic wrap at the side in use
      row_minus_ext = (row_ext == '0) ? side_eff - CW'(1) : row_ext - CW'(1);
      row_plus_ext  = (row_ext + CW'(1) == side_eff) ? '0 : row_ext + CW'(1);
      col_minus_ext = (col_ext == '0) ? side_eff - CW'(1) : col_ext - CW'(1);
      col_plus_ext  = (col_ext + CW'(1) == side_eff) ? '0 : col_ext + CW'(1);

      if (in_range) begin
         row_in       = RW'(row_ext);
         row_up_in    = RW'(row_minus_ext);
         row_dn_in    = RW'(row_plus_ext);
         col_in       = RW'(col_ext);
         col_minus_in = RW'(col_minus_ext);
         col_plus_in  = RW'(col_plus_ext);
      end else begin
         row_in       = '0;
         row_up_in    = '0;
         row_dn_in    = '0;
         col_in       = '0;
         col_minus_in = '0;
         col_plus_in  = '0;
      end

      ctrl_in.command        = cmd_type'(req_command);
      ctrl_in.uniform_sample = req_uniform_sample;
      ctrl_in.spin_value     = req_spin_value;
   end

   isms_row_ram #(.DEPTH(MAX_SIDE), .WIDTH(MAX_SIDE)) u_ram_up (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (s1_row_ff),
      .wr_data (new_row),
      .rd_addr (row_up_in),
      .rd_data (ram_up_q)
   );

   isms_row_ram #(.DEPTH(MAX_SIDE), .WIDTH(MAX_SIDE)) u_ram_mid (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (s1_row_ff),
      .wr_data (new_row),
      .rd_addr (row_in),
      .rd_data (ram_mid_q)
   );

   isms_row_ram #(.DEPTH(MAX_SIDE), .WIDTH(MAX_SIDE)) u_ram_dn (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (s1_row_ff),
      .wr_data (new_row),
      .rd_addr (row_dn_in),
      .rd_data (ram_dn_q)
   );

   // The row written at the edge that sampled these reads is missing from
   // the read data: take it from the forwarding register instead.
   // A row never written reads as all +1.
   always_comb begin
      if (byp_valid_ff && byp_row_ff == s1_row_up_ff) begin
         up_row = byp_data_ff;
      end else begin
         up_row = s1_up_valid_ff ? ram_up_q : '1;
      end
      if (byp_valid_ff && byp_row_ff == s1_row_ff) begin
         mid_row = byp_data_ff;
      end else begin
         mid_row = s1_mid_valid_ff ? ram_mid_q : '1;
      end
      if (byp_valid_ff && byp_row_ff == s1_row_dn_ff) begin
         dn_row = byp_data_ff;
      end else begin
         dn_row = s1_dn_valid_ff ? ram_dn_q : '1;
      end
   end

   isms_site_eval #(.MAX_SIDE(MAX_SIDE)) u_site_eval (
      .up_row       (up_row),
      .mid_row      (mid_row),
      .dn_row       (dn_row),
      .col          (s1_col_ff),
      .col_minus    (s1_col_minus_ff),
      .col_plus     (s1_col_plus_ff),
      .ctrl         (s1_ctrl_ff),
      .thresh_four  (thresh_four_ff),
      .thresh_eight (thresh_eight_ff),
      .new_row      (new_row),
      .result       (eval_res)
   );

   assign wr_en = s1_valid_ff && !s1_range_error_ff && eval_res.write_en;

   always_comb begin
      if (s1_range_error_ff) begin
         rsp_site_spin_in     = 1'b0;
         rsp_flipped_in       = 1'b0;
         rsp_energy_change_in = DE_ZERO;
      end else begin
         rsp_site_spin_in     = eval_res.site_spin;
         rsp_flipped_in       = eval_res.flipped;
         rsp_energy_change_in = eval_res.energy_change;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         side_ff         <= SIDE_RESET;
         thresh_four_ff  <= THRESH_FOUR_RESET;
         thresh_eight_ff <= THRESH_EIGHT_RESET;
         row_valid_ff    <= '0;
         s1_valid_ff     <= 1'b0;
         byp_valid_ff    <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               CSR_SIDE:         side_ff         <= csr_write_data[SIDE_REG_W-1:0];
               CSR_THRESH_FOUR:  thresh_four_ff  <= csr_write_data[THRESH_W-1:0];
               CSR_THRESH_EIGHT: thresh_eight_ff <= csr_write_data[THRESH_W-1:0];
               default: begin
                  // drop writes to unused indexes
               end
            endcase
         end
         if (wr_en) begin
            row_valid_ff[s1_row_ff] <= 1'b1;
         end
         s1_valid_ff  <= accept;
         byp_valid_ff <= wr_en;
         rsp_valid_ff <= s1_valid_ff;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      s1_range_error_ff    <= !in_range;
      s1_ctrl_ff           <= ctrl_in;
      s1_row_ff            <= row_in;
      s1_row_up_ff         <= row_up_in;
      s1_row_dn_ff         <= row_dn_in;
      s1_col_ff            <= col_in;
      s1_col_minus_ff      <= col_minus_in;
      s1_col_plus_ff       <= col_plus_in;
      s1_up_valid_ff       <= row_valid_ff[row_up_in];
      s1_mid_valid_ff      <= row_valid_ff[row_in];
      s1_dn_valid_ff       <= row_valid_ff[row_dn_in];
      byp_row_ff           <= s1_row_ff;
      byp_data_ff          <= new_row;
      rsp_site_spin_ff     <= rsp_site_spin_in;
      rsp_flipped_ff       <= rsp_flipped_in;
      rsp_energy_change_ff <= rsp_energy_change_in;
      rsp_range_error_ff   <= s1_range_error_ff;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_site_spin     = rsp_site_spin_ff;
   assign rsp_flipped       = rsp_flipped_ff;
   assign rsp_energy_change = signed'(rsp_energy_change_ff);
   assign rsp_range_error   = rsp_range_error_ff;

endmodule

/* hw/rtl/isms_row_ram.sv */
// ----------------------------------------------------------------------------
// isms_row_ram
// One copy of the spin lattice, one row per word: one write port and one
// read port with registered read data (old data on a same-address collision).
// ----------------------------------------------------------------------------
module isms_row_ram #(
   parameter int  DEPTH = 32,
   parameter int  WIDTH = 32,
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* hw/rtl/isms_site_eval.sv */
// ----------------------------------------------------------------------------
// isms_site_eval
// Metropolis decision for one site: count the four neighbors, form the
// energy change, test acceptance and build the updated center row for an
// update or a write.
module isms_site_eval #(
   parameter int  MAX_SIDE = 32,
   localparam int RW       = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1
) (
   input  logic [MAX_SIDE-1:0]           up_row,
   input  logic [MAX_SIDE-1:0]           mid_row,
   input  logic [MAX_SIDE-1:0]           dn_row,
   input  logic [RW-1:0]                 col,
   input  logic [RW-1:0]                 col_minus,
   input  logic [RW-1:0]                 col_plus,
   input  isms_pkg::eval_ctrl_type       ctrl,
   input  logic [isms_pkg::THRESH_W-1:0] thresh_four,
   input  logic [isms_pkg::THRESH_W-1:0] thresh_eight,
   output logic [MAX_SIDE-1:0]           new_row,
   output isms_pkg::eval_result_type     result
);

   import isms_pkg::*;

   logic                   spin;
   logic [2:0]             up_count;
   logic signed [DE_W-1:0] de_if_up;
   logic signed [DE_W-1:0] de;
   logic [THRESH_W-1:0]    sample_ext;
   logic                   accept;
   logic                   new_spin;

   always_comb begin
      spin     = mid_row[col];
      up_count = 3'(mid_row[col_minus]) + 3'(mid_row[col_plus])
               + 3'(up_row[col]) + 3'(dn_row[col]);
      // dE = 2*s*sum with sum = 2*n - 4: for s = +1 it is 4n - 8
      de_if_up   = signed'({up_count, 2'b00}) - DE_EIGHT;
      de         = spin ? de_if_up : -de_if_up;
      sample_ext = THRESH_W'(ctrl.uniform_sample);

      if (de[DE_W-1] || de == DE_ZERO) begin
         accept = 1'b1;
      end else if (de == DE_FOUR) begin
         accept = sample_ext < thresh_four;
      end else begin
         accept = sample_ext < thresh_eight;
      end

      result.flipped       = 1'b0;
      result.energy_change = DE_ZERO;
      result.write_en      = 1'b0;
      new_spin             = spin;
      case (ctrl.command)
         CMD_UPDATE: begin
            result.flipped       = accept;
            result.energy_change = de;
            result.write_en      = 1'b1;
            new_spin             = spin ^ accept;
         end
         CMD_WRITE: begin
            result.write_en = 1'b1;
            new_spin        = ctrl.spin_value;
         end
         default: begin
            // read, and the unused code: leave the site alone
            new_spin = spin;
         end
      endcase

      result.site_spin = new_spin;
      new_row          = mid_row;
      new_row[col]     = new_spin;
   end

endmodule

/* hw/rtl/isms_checker.sv */
// ----------------------------------------------------------------------------
// isms_checker
// Port-level checks for the spin update core: result timing, busy level and
// consistency of the result word fields.
// ----------------------------------------------------------------------------
module isms_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             start,
   input logic                             busy,
   input logic                             rsp_valid,
   input logic                             rsp_site_spin,
   input logic                             rsp_flipped,
   input logic signed [isms_pkg::DE_W-1:0] rsp_energy_change,
   input logic                             rsp_range_error
);

   import isms_pkg::*;

   a_accept_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##2 rsp_valid)
      else $error("accepted word produced no result strobe");

   a_no_spurious_rsp: assert property (@(posedge clock) disable iff (reset)
      !(start && !busy) |-> ##2 !rsp_valid)
      else $error("result strobe without an accepted word");

   a_never_busy: assert property (@(posedge clock) disable iff (reset)
      !busy)
      else $error("busy raised");

   a_range_error_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_range_error) |->
         (!rsp_site_spin && !rsp_flipped && rsp_energy_change == DE_ZERO))
      else $error("range error word carries update data");

   // result fields are only meaningful while the strobe is high
   a_flip_legal: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_flipped) |->
         (!rsp_range_error &&
          (rsp_energy_change == DE_ZERO || rsp_energy_change == DE_FOUR ||
           rsp_energy_change == DE_EIGHT || rsp_energy_change == -DE_FOUR ||
           rsp_energy_change == -DE_EIGHT)))
      else $error("flip reported with an illegal energy change");

endmodule

bind ising_metropolis_spin_update_core isms_checker u_isms_checker (.*);
